/* hdl/trem_pkg.sv */
// Shared widths, constants, register indexes and control types for the
// tremolo modulator. No dependencies; imported by every module of the block.
package trem_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int COUNT_BITS = 17;

    localparam int SAMPLE_W = 16;
    localparam int HALF_W   = 17;
    localparam int STEP_W   = 26;
    localparam int WAVE_W   = 2;
    localparam int CFG_W    = 26;
    localparam int INDEX_W  = 2;

    localparam int QW     = FRAC_BITS + 2;
    localparam int CMP_W  = (COUNT_BITS > HALF_W) ? COUNT_BITS : HALF_W;
    localparam int TRI_W  = ((QW > STEP_W) ? QW : STEP_W) + 2;
    localparam int PM_W   = QW + STEP_W + 2;
    localparam int PAR_W  = PM_W - FRAC_BITS + 1;
    localparam int SUM_W  = (TRI_W > PAR_W) ? TRI_W : PAR_W;
    localparam int AMP_W  = QW + 1;
    localparam int OW     = SAMPLE_W + AMP_W;
    localparam int OSHIFT = FRAC_BITS + 1;

    localparam logic signed [QW-1:0] Q_ONE     = QW'(64'd1 << FRAC_BITS);
    localparam logic signed [QW-1:0] Q_NEG_ONE = -Q_ONE;
    localparam longint SLEW_INT = ((64'd1 << (FRAC_BITS + 1)) + 64'd50) / 64'd100;
    localparam logic signed [QW-1:0] Q_SLEW    = QW'(SLEW_INT);
    localparam logic [OW-1:0] OUT_BIAS = OW'((64'd1 << OSHIFT) - 64'd1);

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(24000);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1398);

    localparam logic [INDEX_W-1:0] REG_HALF = 2'd0;
    localparam logic [INDEX_W-1:0] REG_STEP = 2'd1;
    localparam logic [INDEX_W-1:0] REG_WAVE = 2'd2;

    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd0;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [WAVE_W-1:0] WAVE_PARABOLA = 2'd2;

    typedef struct packed {
        logic accept;
        logic pmul;
        logic par;
        logic amul;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic signed [QW-1:0] clamp_unit(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(Q_ONE)) begin
            return Q_ONE;
        end
        if (v < SUM_W'(Q_NEG_ONE)) begin
            return Q_NEG_ONE;
        end
        return QW'(v);
    endfunction

endpackage

/* hdl/trem_ctrl.sv */
// Sequencer for the tremolo modulator: steps one sample through the datapath.
// Depends on trem_pkg for the command and status types.
module trem_ctrl import trem_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PMUL = 3'd1;
    localparam logic [2:0] ST_PAR  = 3'd2;
    localparam logic [2:0] ST_AMUL = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_PMUL;
                end
            end
            ST_PMUL: begin
                o_cmd.pmul = 1'b1;
                n_state    = ST_PAR;
            end
            ST_PAR: begin
                o_cmd.par = 1'b1;
                n_state   = ST_AMUL;
            end
            ST_AMUL: begin
                o_cmd.amul = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.load = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/trem_datapath.sv */
// Oscillator state, configuration registers, multipliers and output register
// of the tremolo modulator. Depends on trem_pkg; driven by trem_ctrl.
module trem_datapath import trem_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    input  logic                       i_cfg_valid,
    input  logic [INDEX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic signed [SAMPLE_W-1:0] i_audio_in,
    input  logic                       i_block_start,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic signed [SAMPLE_W-1:0] o_audio_out
);

    logic [HALF_W-1:0] r_half;
    logic [STEP_W-1:0] r_step;
    logic [WAVE_W-1:0] r_wave;

    logic [COUNT_BITS-1:0] r_count;
    logic                  r_neg;
    logic signed [QW-1:0]  r_smooth;
    logic signed [QW-1:0]  r_tri;
    logic signed [QW-1:0]  r_par;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [PM_W-1:0]     r_pprod;
    logic signed [AMP_W-1:0]    r_amp;
    logic signed [OW-1:0]       r_prod;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out;

    logic [COUNT_BITS-1:0] eff_count;
    logic                  eff_neg;
    logic signed [QW-1:0]  eff_smooth;
    logic signed [QW-1:0]  eff_tri;
    logic                  flip;
    logic                  n_neg;
    logic [COUNT_BITS-1:0] n_count;
    logic signed [QW-1:0]  sq;
    logic signed [SUM_W-1:0] smooth_sum;
    logic signed [SUM_W-1:0] tri_sum;
    logic signed [QW-1:0]  n_smooth;
    logic signed [QW-1:0]  n_tri;
    logic signed [SUM_W-1:0] par_sum;
    logic signed [QW-1:0]  n_par;
    logic signed [QW-1:0]  w;
    logic signed [PM_W-1:0] step2;
    logic signed [OW-1:0]  biased;
    logic signed [OW-1:0]  shifted;
    logic                  n_out_valid;

    always_comb begin
        eff_count  = i_block_start ? '0 : r_count;
        eff_neg    = i_block_start ? 1'b0 : r_neg;
        eff_smooth = i_block_start ? Q_ONE : r_smooth;
        eff_tri    = i_block_start ? Q_NEG_ONE : r_tri;
        flip       = CMP_W'(eff_count) > CMP_W'(r_half);
        n_neg      = eff_neg ^ flip;
        n_count    = (flip ? '0 : eff_count) + COUNT_BITS'(1);
        sq         = n_neg ? Q_NEG_ONE : Q_ONE;
        if (sq > eff_smooth) begin
            smooth_sum = SUM_W'(eff_smooth) + SUM_W'(Q_SLEW);
        end else if (sq < eff_smooth) begin
            smooth_sum = SUM_W'(eff_smooth) - SUM_W'(Q_SLEW);
        end else begin
            smooth_sum = SUM_W'(eff_smooth);
        end
        n_smooth = clamp_unit(smooth_sum);
        if (n_neg) begin
            tri_sum = SUM_W'(eff_tri) - SUM_W'({1'b0, r_step});
        end else begin
            tri_sum = SUM_W'(eff_tri) + SUM_W'({1'b0, r_step});
        end
        n_tri = clamp_unit(tri_sum);
    end

    always_comb begin
        step2   = PM_W'({1'b0, r_step, 1'b0});
        par_sum = SUM_W'(r_par) + SUM_W'(r_pprod >>> FRAC_BITS);
        n_par   = clamp_unit(par_sum);
        unique case (r_wave)
            WAVE_TRIANGLE: w = r_tri;
            WAVE_PARABOLA: w = n_par;
            default:       w = r_smooth;
        endcase
        biased  = r_prod + (r_prod[OW-1] ? OUT_BIAS : '0);
        shifted = biased >>> OSHIFT;
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign n_out_valid       = i_cmd.load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= HALF_RESET;
            r_step      <= STEP_RESET;
            r_wave      <= WAVE_PARABOLA;
            r_count     <= '0;
            r_neg       <= 1'b0;
            r_smooth    <= Q_ONE;
            r_tri       <= Q_NEG_ONE;
            r_par       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_HALF: r_half <= i_cfg_data[HALF_W-1:0];
                    REG_STEP: r_step <= i_cfg_data[STEP_W-1:0];
                    REG_WAVE: r_wave <= i_cfg_data[WAVE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                r_count  <= n_count;
                r_neg    <= n_neg;
                r_smooth <= n_smooth;
                r_tri    <= n_tri;
                if (i_block_start) begin
                    r_par <= '0;
                end
            end
            if (i_cmd.par) begin
                r_par <= n_par;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_audio_in;
        end
        if (i_cmd.pmul) begin
            r_pprod <= PM_W'(r_tri) * step2;
        end
        if (i_cmd.par) begin
            r_amp <= AMP_W'(w) + AMP_W'(Q_ONE);
        end
        if (i_cmd.amul) begin
            r_prod <= OW'(r_sample) * OW'(r_amp);
        end
        if (i_cmd.load) begin
            r_out <= shifted[SAMPLE_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_audio_out = r_out;

endmodule

/* hdl/tremolo_lfo_modulator.sv */
// Tremolo modulator: each sample steps through the block one controller
// state at a time (an accept state that also advances the square, slew and
// triangle states, then the parabola multiply, the parabola update and
// waveform pick, the amplitude multiply, and the output load). The result
// is loaded into the output register in the load state, and no new transfer
// is taken until the previous sample has been loaded. The chain of two
// dependent multiplies sets this sequence. A waiting result stalls the last
// step only. Configuration writes are always ready and apply at once.
// Depends on trem_pkg, trem_ctrl and trem_datapath.
module tremolo_lfo_modulator import trem_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [INDEX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_audio_in,
    input  logic                       i_block_start,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_audio_out
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    trem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    trem_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_audio_in    (i_audio_in),
        .i_block_start (i_block_start),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_audio_out   (o_audio_out)
    );

endmodule
